[sv/line_deframer_mod99_check_assert.svh]
// Assertion macros for the line deframer.
`ifndef LINE_DEFRAMER_MOD99_CHECK_ASSERT_SVH
`define LINE_DEFRAMER_MOD99_CHECK_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LDM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LDM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ldm_pkg.sv]
`default_nettype none

package ldm_pkg;

    localparam int MAX_LINE = 256;
    localparam int CNT_W    = $clog2(MAX_LINE + 1);

    typedef logic [CNT_W-1:0] t_cnt;

    // Last position before the limit: a non-newline byte here ends the frame.
    localparam t_cnt LAST_POS = t_cnt'(MAX_LINE - 1);

    localparam logic [7:0] CH_START   = 8'h3B;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TOP     = 8'h7F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] SUM_MOD    = 8'd99;

    typedef struct packed {
        logic       have;
        logic [7:0] frame_byte;
        logic       is_last;
        logic       header_ok;
        logic       sum_match;
        logic       truncated;
    } t_result;

endpackage

`default_nettype wire

[sv/ldm_frame.sv]
`default_nettype none

module ldm_frame (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_fire,
    input  wire logic [7:0]      i_byte,
    output ldm_pkg::t_result     o_res
);
    import ldm_pkg::*;

    logic       r_in_frame;
    t_cnt       r_count;
    logic [6:0] r_sum;
    logic [3:0] r_tens;
    logic [3:0] r_units;
    logic       r_dv;

    logic       n_in_frame;
    t_cnt       n_count;
    logic [6:0] n_sum;
    logic [3:0] n_tens;
    logic [3:0] n_units;
    logic       n_dv;

    logic       is_digit;
    logic [3:0] digit_val;
    logic [7:0] sum_0;
    logic [7:0] sum_1;
    logic [7:0] sum_2;
    logic [6:0] check_val;
    logic       last;

    assign is_digit  = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign digit_val = is_digit ? 4'(i_byte - CH_ZERO) : 4'd0;

    // Incremental mod 99: sum < 99 + 128, so at most two subtractions.
    assign sum_0 = {1'b0, r_sum} + {1'b0, i_byte[6:0]};
    assign sum_1 = (sum_0 >= SUM_MOD) ? sum_0 - SUM_MOD : sum_0;
    assign sum_2 = (sum_1 >= SUM_MOD) ? sum_1 - SUM_MOD : sum_1;

    // tens * 10 + units, at most 99
    assign check_val = {r_tens, 3'b000} + {2'b00, r_tens, 1'b0} + {3'b000, r_units};

    always_comb begin
        n_in_frame = r_in_frame;
        n_count    = r_count;
        n_sum      = r_sum;
        n_tens     = r_tens;
        n_units    = r_units;
        n_dv       = r_dv;
        last       = 1'b0;
        o_res      = '0;
        o_res.frame_byte = i_byte;

        if (!r_in_frame) begin
            if (i_byte == CH_START) begin
                o_res.have = 1'b1;
                n_in_frame = 1'b1;
                n_count    = t_cnt'(1);
                n_sum      = '0;
                n_tens     = '0;
                n_units    = '0;
                n_dv       = 1'b1;
            end
        end else begin
            o_res.have = 1'b1;
            if (i_byte == CH_NEWLINE) begin
                last            = 1'b1;
                o_res.header_ok = r_dv && (r_count >= t_cnt'(3));
                o_res.sum_match = o_res.header_ok &&
                                  (({1'b0, r_sum} + 8'd1) == {1'b0, check_val});
            end else begin
                if (r_count == t_cnt'(1) || r_count == t_cnt'(2)) begin
                    if (!is_digit) begin
                        n_dv = 1'b0;
                    end
                    if (r_count == t_cnt'(1)) begin
                        n_tens = digit_val;
                    end else begin
                        n_units = digit_val;
                    end
                end else if (i_byte >= CH_SPACE && i_byte <= CH_TOP) begin
                    n_sum = sum_2[6:0];
                end
                if (r_count >= LAST_POS) begin
                    last            = 1'b1;
                    o_res.truncated = 1'b1;
                    o_res.header_ok = n_dv && (r_count >= t_cnt'(2));
                end
            end
            if (last) begin
                n_in_frame = 1'b0;
                n_count    = '0;
            end else begin
                n_count = r_count + t_cnt'(1);
            end
        end
        o_res.is_last = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_count    <= '0;
            r_sum      <= '0;
            r_tens     <= '0;
            r_units    <= '0;
            r_dv       <= 1'b0;
        end else if (i_fire) begin
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
            r_sum      <= n_sum;
            r_tens     <= n_tens;
            r_units    <= n_units;
            r_dv       <= n_dv;
        end
    end

endmodule

`default_nettype wire

[sv/line_deframer_mod99_check.sv]
// Path: input register r_in_byte, then result register r_out, which drives o_valid.
// Throughput: one byte per cycle unless stalled; the frame state register updates once per byte.
// A byte that lies outside a frame (not ';') is consumed with no transaction out.
// Reset (i_rst_n low, synchronous) closes any open frame and empties both
// the input and the result register.
`default_nettype none

`include "line_deframer_mod99_check_assert.svh"

module line_deframer_mod99_check (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_frame_byte,
    output logic            o_is_last,
    output logic            o_header_ok,
    output logic            o_sum_match,
    output logic            o_truncated
);
    import ldm_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    logic       out_free;
    logic       fire;
    logic       in_take;
    t_result    res;

    assign out_free = !r_out_valid || !i_stall;
    assign fire     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    ldm_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= res.have;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_frame_byte = r_out.frame_byte;
    assign o_is_last    = r_out.is_last;
    assign o_header_ok  = r_out.header_ok;
    assign o_sum_match  = r_out.sum_match;
    assign o_truncated  = r_out.truncated;

    `LDM_ASSERT_NOW(a_flags_only_on_last, i_clk, i_rst_n, o_valid && !o_is_last,
        !o_header_ok && !o_sum_match && !o_truncated,
        "status flags set on a non-final frame byte")
    `LDM_ASSERT_NOW(a_match_needs_header, i_clk, i_rst_n, o_valid && o_sum_match,
        o_header_ok && !o_truncated, "sum match without valid header or on truncation")
    `LDM_ASSERT_NOW(a_trunc_is_last, i_clk, i_rst_n, o_valid && o_truncated, o_is_last,
        "truncation flagged on a non-final byte")
    `LDM_ASSERT_NEXT(a_drop_no_output, i_clk, i_rst_n, fire && !res.have, !o_valid,
        "dropped idle byte produced a transaction")

endmodule

`default_nettype wire

[tb/line_deframer_result_checker.sv]
`default_nettype none

module line_deframer_result_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_rx_valid,
    input  wire logic       i_rx_stall,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_res_valid,
    input  wire logic       i_res_stall,
    input  wire logic [7:0] i_frame_byte,
    input  wire logic       i_is_last,
    input  wire logic       i_header_ok,
    input  wire logic       i_sum_match,
    input  wire logic       i_truncated,
    output int              o_fail_count,
    output int              o_pending
);
    import ldm_pkg::*;

    localparam int DEC_BASE = 10;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       is_last;
        logic       header_ok;
        logic       sum_match;
        logic       truncated;
    } t_line_result;

    t_line_result line_result_q[$];
    int           mism_count;

    // predicted deframer state
    logic       in_frame;
    t_cnt       byte_cnt;
    logic [6:0] run_sum;
    logic [3:0] tens_val;
    logic [3:0] units_val;
    logic       digits_ok;

    task automatic clear_frame_state();
        in_frame  = 1'b0;
        byte_cnt  = '0;
        run_sum   = '0;
        tens_val  = '0;
        units_val = '0;
        digits_ok = 1'b0;
    endtask

    // Advance the predicted state by one received byte; queue the frame byte it yields.
    task automatic track_rx_byte(input logic [7:0] b);
        t_line_result r;
        int           pos;
        logic [3:0]   val;
        r = '0;
        r.frame_byte = b;
        if (!in_frame) begin
            if (b == CH_START) begin
                clear_frame_state();
                in_frame  = 1'b1;
                byte_cnt  = t_cnt'(1);
                digits_ok = 1'b1;
                line_result_q.push_back(r);
            end
        end else begin
            pos = int'(byte_cnt);
            if (b == CH_NEWLINE) begin
                r.is_last   = 1'b1;
                r.header_ok = digits_ok && pos >= 3;
                r.sum_match = r.header_ok &&
                    (int'(run_sum) + 1 == int'(tens_val) * DEC_BASE + int'(units_val));
            end else begin
                if (pos == 1 || pos == 2) begin
                    val = '0;
                    if (b >= CH_ZERO && b <= CH_NINE)
                        val = 4'(b - CH_ZERO);
                    else
                        digits_ok = 1'b0;
                    if (pos == 1)
                        tens_val = val;
                    else
                        units_val = val;
                end else if (b >= CH_SPACE && b <= CH_TOP) begin
                    run_sum = 7'((int'(run_sum) + int'(b)) % int'(SUM_MOD));
                end
                if (pos + 1 >= MAX_LINE) begin
                    r.is_last   = 1'b1;
                    r.truncated = 1'b1;
                    r.header_ok = digits_ok && pos >= 2;
                end
            end
            if (r.is_last) begin
                in_frame = 1'b0;
                byte_cnt = '0;
            end else begin
                byte_cnt = t_cnt'(pos + 1);
            end
            line_result_q.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mism_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_line_result want;
        if (!i_rst_n) begin
            clear_frame_state();
            line_result_q.delete();
            mism_count = 0;
        end else begin
            if (i_rx_valid && !i_rx_stall)
                track_rx_byte(i_rx_byte);
            if (i_res_valid && !i_res_stall) begin
                if (line_result_q.size() == 0) begin
                    $error("unexpected transaction: frame_byte 0x%0h", i_frame_byte);
                    mism_count++;
                end else begin
                    want = line_result_q.pop_front();
                    check_field("frame_byte", want.frame_byte, i_frame_byte);
                    check_field("is_last", 8'(want.is_last), 8'(i_is_last));
                    check_field("header_ok", 8'(want.header_ok), 8'(i_header_ok));
                    check_field("sum_match", 8'(want.sum_match), 8'(i_sum_match));
                    check_field("truncated", 8'(want.truncated), 8'(i_truncated));
                end
            end
        end
        o_fail_count <= mism_count;
        o_pending    <= line_result_q.size();
    end

endmodule

`default_nettype wire

[tb/tb_line_deframer_mod99_check.sv]
`default_nettype none

module tb_line_deframer_mod99_check;

    import ldm_pkg::*;

    localparam int QUIET_LIMIT = 4000;

    typedef logic [7:0] t_byte_seq[$];

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       rx_valid  = 1'b0;
    logic [7:0] rx_byte   = 8'h00;
    logic       res_stall = 1'b0;
    logic       rx_stall;
    logic       res_valid;
    logic [7:0] res_frame_byte;
    logic       res_is_last;
    logic       res_header_ok;
    logic       res_sum_match;
    logic       res_truncated;
    int         fail_count;
    int         pending_count;

    int send_idle_pct  = 12;
    int res_stall_pct  = 87;
    int sent_items     = 0;
    int quiet_cycles   = 0;

    line_deframer_mod99_check u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (rx_valid),
        .o_stall      (rx_stall),
        .i_rx_byte    (rx_byte),
        .o_valid      (res_valid),
        .i_stall      (res_stall),
        .o_frame_byte (res_frame_byte),
        .o_is_last    (res_is_last),
        .o_header_ok  (res_header_ok),
        .o_sum_match  (res_sum_match),
        .o_truncated  (res_truncated)
    );

    line_deframer_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_rx_valid   (rx_valid),
        .i_rx_stall   (rx_stall),
        .i_rx_byte    (rx_byte),
        .i_res_valid  (res_valid),
        .i_res_stall  (res_stall),
        .i_frame_byte (res_frame_byte),
        .i_is_last    (res_is_last),
        .i_header_ok  (res_header_ok),
        .i_sum_match  (res_sum_match),
        .i_truncated  (res_truncated),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        res_stall <= ($urandom_range(99) < res_stall_pct);
    end

    // watchdog: consecutive cycles with no transaction on either side
    always @(posedge clk) begin
        if (!rst_n || (rx_valid && !rx_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (rx_stall)
            @(posedge clk);
        sent_items++;
    endtask

    // Sender holds off until every predicted result has come back.
    task automatic drain_results();
        rx_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_count != 0);
    endtask

    function automatic logic [7:0] any_but_newline();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (b == CH_NEWLINE)
            b = 8'($urandom_range(255));
        return b;
    endfunction

    function automatic t_byte_seq rand_payload(input int n, input int wild_pct);
        t_byte_seq p;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < wild_pct)
                p.push_back(any_but_newline());
            else
                p.push_back(8'($urandom_range(CH_TOP, CH_SPACE)));
        end
        return p;
    endfunction

    // Check digits that make a payload pass: (printable sum mod 99) + 1.
    function automatic logic [15:0] check_chars(input t_byte_seq p);
        int acc;
        int v;
        acc = 0;
        foreach (p[i])
            if (p[i] >= CH_SPACE && p[i] <= CH_TOP)
                acc = (acc + int'(p[i])) % int'(SUM_MOD);
        v = acc + 1;
        return {CH_ZERO + 8'(v / 10), CH_ZERO + 8'(v % 10)};
    endfunction

    task automatic send_line(input logic [7:0] d1, input logic [7:0] d2,
                             input t_byte_seq payload, input logic [7:0] tail);
        send_byte(CH_START);
        send_byte(d1);
        send_byte(d2);
        foreach (payload[i])
            send_byte(payload[i]);
        send_byte(tail);
    endtask

    task automatic send_good_line(input t_byte_seq payload);
        logic [15:0] chk;
        chk = check_chars(payload);
        send_line(chk[15:8], chk[7:0], payload, CH_NEWLINE);
    endtask

    // Line that reaches MAX_LINE bytes; last byte is either a newline or truncates.
    task automatic long_line(input bit newline_at_limit);
        t_byte_seq   pl;
        logic [15:0] chk;
        pl  = rand_payload(MAX_LINE - 4, 10);
        chk = check_chars(pl);
        send_line(chk[15:8], chk[7:0], pl,
                  newline_at_limit ? CH_NEWLINE : any_but_newline());
    endtask

    task automatic random_line();
        t_byte_seq   pl;
        logic [15:0] chk;
        logic [7:0]  d1;
        logic [7:0]  d2;
        logic [7:0]  b;
        int          kind;
        kind = $urandom_range(99);
        // idle noise between frames, never a start character
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(3, 1)) begin
                b = 8'($urandom_range(255));
                if (b == CH_START)
                    b = CH_NEWLINE;
                send_byte(b);
            end
        end
        pl  = rand_payload($urandom_range(24), (kind >= 88 && kind < 94) ? 100 : 15);
        chk = check_chars(pl);
        d1  = chk[15:8];
        d2  = chk[7:0];
        if (kind >= 65 && kind < 75) begin
            d1 = CH_ZERO + 8'($urandom_range(9));
            d2 = CH_ZERO + 8'($urandom_range(9));
        end else if (kind >= 75 && kind < 83) begin
            if ($urandom_range(1))
                d1 = any_but_newline();
            else
                d2 = any_but_newline();
        end
        if (kind >= 83 && kind < 88) begin
            // newline where a check digit belongs
            send_byte(CH_START);
            if ($urandom_range(1))
                send_byte(d1);
            send_byte(CH_NEWLINE);
        end else begin
            // full line; for kind >= 94 it is left unterminated and runs into the next one
            send_line(d1, d2, pl, (kind >= 94) ? CH_START : CH_NEWLINE);
        end
    endtask

    task automatic run_random(input int item_goal);
        while (sent_items < item_goal) begin
            if ($urandom_range(49) == 0)
                drain_results();
            random_line();
        end
    endtask

    initial begin
        t_byte_seq empty_pl;
        t_byte_seq mixed_pl;
        t_byte_seq top_pl;
        t_byte_seq space_pl;
        empty_pl = {};
        mixed_pl = {CH_START, 8'h1F, 8'h80, 8'hFF, CH_TOP, 8'h21};
        top_pl   = {8'h62};
        space_pl = {CH_SPACE};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // phase 1: sender mostly busy, receiver mostly stalled
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_NEWLINE);
        send_byte(CH_START);
        send_byte(CH_NEWLINE);
        send_byte(CH_START);
        send_byte(CH_ZERO + 8'd5);
        send_byte(CH_NEWLINE);
        send_good_line(empty_pl);
        send_line(CH_ZERO, CH_ZERO, empty_pl, CH_NEWLINE);
        send_line(8'h78, CH_ZERO + 8'd1, space_pl, CH_NEWLINE);
        send_good_line(mixed_pl);
        send_good_line(top_pl);
        drain_results();
        long_line(1'b0);
        run_random(370);
        drain_results();

        // phase 2: sender mostly idle, receiver mostly ready
        send_idle_pct = 87;
        res_stall_pct = 12;
        long_line(1'b1);
        run_random(720);
        drain_results();

        // phase 3: full rate both ways
        send_idle_pct = 0;
        res_stall_pct = 0;
        run_random(1060);
        drain_results();

        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
